/* src/partial_reliability_receiver_defines.svh */
// Assertion macros used by the partial-reliability receiver RTL.
`ifndef PARTIAL_RELIABILITY_RECEIVER_DEFINES_SVH
`define PARTIAL_RELIABILITY_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PRR_ASSERT_IMPL(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("%m: check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PRR_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("%m: check failed");

`endif

/* src/prr_pkg.sv */
// Types and constants of the partial-reliability receiver.
package prr_pkg;

   localparam int WINDOW_DEFAULT = 128;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_INDEX_W    = 2;
   localparam int LOSS_SCALE     = 100;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_LOCAL_SEQ   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ACK_TIMEOUT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LOCAL_PORT  = 2'd2;

   typedef struct packed {
      logic [31:0] seq_num;
      logic [31:0] ack_number;
      logic [7:0]  syn_byte;
      logic        ack_flag;
      logic [15:0] peer_port;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic        send_reply;
      logic        reply_syn;
      logic [31:0] reply_seq;
      logic [31:0] reply_ack_num;
      logic [15:0] reply_src_port;
      logic [15:0] reply_dest_port;
      logic        deliver_payload;
      logic        loss_accepted;
      logic [1:0]  link_state;
   } rsp_type;

endpackage

/* src/prr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module prr_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/partial_reliability_receiver.sv */
// Top level of the partial-reliability receiver: handshake, delivery and loss tolerance.
//
//   channel  direction  handshake               content
//   req      in         req_valid / req_ready   one received PDU header per item
//   rsp      out        rsp_valid / rsp_ready   one reply and status item per request
//   csr      in         csr_wen, no wait        initial seq, ACK timeout, local port
//
// One item is accepted per cycle unless stalled; its result is registered for the next cycle.
// The loss history RAM always holds the entry at the current index on its read port, because
// the next index is presented for reading in the cycle the current one is written.
// Reset is synchronous; the history reads as all received until the index first wraps, so
// there is no clearing pass. req_ready is high whenever the output register is empty or taken.
module partial_reliability_receiver #(
   parameter int WINDOW = prr_pkg::WINDOW_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  prr_pkg::req_type                req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output prr_pkg::rsp_type                rsp_payload,
   input  logic                            csr_wen,
   input  logic [prr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [prr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import prr_pkg::*;

   `include "partial_reliability_receiver_defines.svh"

   localparam int HIST_AW = $clog2(WINDOW);
   localparam int LOSS_W  = $clog2(WINDOW + 1);
   localparam int CMP_W   = LOSS_W + 8;

   localparam logic [1:0] ST_LISTEN    = 2'd0;
   localparam logic [1:0] ST_WAIT_ACK  = 2'd1;
   localparam logic [1:0] ST_CONNECTED = 2'd2;

   logic [31:0]        local_seq_ff, local_seq_in;
   logic [15:0]        ack_timeout_ff, ack_timeout_in;
   logic [15:0]        local_port_ff, local_port_in;

   logic [1:0]         state_ff, state_in;
   logic [31:0]        peer_seq_ff, peer_seq_in;
   logic [6:0]         loss_pct_ff, loss_pct_in;
   logic [31:0]        hs_start_ff, hs_start_in;
   logic               exp_bit_ff, exp_bit_in;
   logic [HIST_AW-1:0] hist_idx_ff, hist_idx_in;
   logic               hist_wrapped_ff, hist_wrapped_in;
   logic [LOSS_W-1:0]  lost_count_ff, lost_count_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_payload_ff, rsp_payload_in;

   logic               req_fire;
   logic               hist_wr;
   logic               hist_bit;
   logic               hist_rd;
   logic               hist_old;
   logic [CMP_W-1:0]   lost_scaled;
   logic [CMP_W-1:0]   allowed_scaled;
   logic               seq_match;
   logic [31:0]        elapsed;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // Until the index has wrapped once, the entry under it has never been written.
   assign hist_old = hist_wrapped_ff ? hist_rd : 1'b1;

   assign lost_scaled    = CMP_W'(lost_count_ff) * CMP_W'(LOSS_SCALE);
   assign allowed_scaled = CMP_W'(loss_pct_ff) * CMP_W'(WINDOW);
   assign seq_match      = (req_payload.seq_num == {31'd0, exp_bit_ff});
   assign elapsed        = req_payload.now_ms - hs_start_ff;

   always_comb begin
      local_seq_in    = local_seq_ff;
      ack_timeout_in  = ack_timeout_ff;
      local_port_in   = local_port_ff;
      if (csr_wen) begin
         unique case (csr_index)
            REG_LOCAL_SEQ:   local_seq_in   = csr_wdata;
            REG_ACK_TIMEOUT: ack_timeout_in = csr_wdata[15:0];
            REG_LOCAL_PORT:  local_port_in  = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in        = state_ff;
      peer_seq_in     = peer_seq_ff;
      loss_pct_in     = loss_pct_ff;
      hs_start_in     = hs_start_ff;
      exp_bit_in      = exp_bit_ff;
      hist_idx_in     = hist_idx_ff;
      hist_wrapped_in = hist_wrapped_ff;
      lost_count_in   = lost_count_ff;
      hist_wr         = 1'b0;
      hist_bit        = 1'b1;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_payload_in  = rsp_payload_ff;

      if (req_fire) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = '0;
         unique case (state_ff)
            ST_CONNECTED: begin
               if (seq_match) begin
                  hist_wr  = 1'b1;
                  hist_bit = 1'b1;
                  rsp_payload_in.deliver_payload = 1'b1;
               end else if (lost_scaled <= allowed_scaled) begin
                  hist_wr  = 1'b1;
                  hist_bit = 1'b0;
                  rsp_payload_in.loss_accepted = 1'b1;
               end
               if (hist_wr) begin
                  exp_bit_in = !exp_bit_ff;
                  if (hist_old && !hist_bit) begin
                     lost_count_in = lost_count_ff + 1'b1;
                  end else if (!hist_old && hist_bit && lost_count_ff != '0) begin
                     lost_count_in = lost_count_ff - 1'b1;
                  end
                  if (hist_idx_ff == HIST_AW'(WINDOW - 1)) begin
                     hist_idx_in     = '0;
                     hist_wrapped_in = 1'b1;
                  end else begin
                     hist_idx_in = hist_idx_ff + 1'b1;
                  end
               end
               rsp_payload_in.send_reply      = 1'b1;
               rsp_payload_in.reply_ack_num   = {31'd0, exp_bit_in};
               rsp_payload_in.reply_src_port  = local_port_ff;
               rsp_payload_in.reply_dest_port = req_payload.peer_port;
            end
            ST_WAIT_ACK: begin
               if (req_payload.ack_flag && req_payload.seq_num == peer_seq_ff + 32'd1 &&
                   req_payload.ack_number == local_seq_ff + 32'd1) begin
                  state_in = ST_CONNECTED;
               end else if (elapsed > {16'd0, ack_timeout_ff}) begin
                  hs_start_in = '0;
                  loss_pct_in = '0;
                  state_in    = ST_LISTEN;
               end
            end
            default: begin
               // Listening; the unused code behaves the same way.
               if (req_payload.syn_byte[7]) begin
                  loss_pct_in = req_payload.syn_byte[6:0];
                  peer_seq_in = req_payload.seq_num;
                  hs_start_in = req_payload.now_ms;
                  state_in    = ST_WAIT_ACK;
                  rsp_payload_in.send_reply      = 1'b1;
                  rsp_payload_in.reply_syn       = 1'b1;
                  rsp_payload_in.reply_seq       = local_seq_ff;
                  rsp_payload_in.reply_ack_num   = req_payload.seq_num + 32'd1;
                  rsp_payload_in.reply_src_port  = local_port_ff;
                  rsp_payload_in.reply_dest_port = req_payload.peer_port;
               end
            end
         endcase
         rsp_payload_in.link_state = state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_seq_ff    <= 32'd20;
         ack_timeout_ff  <= 16'd10;
         local_port_ff   <= '0;
         state_ff        <= ST_LISTEN;
         peer_seq_ff     <= '0;
         loss_pct_ff     <= '0;
         hs_start_ff     <= '0;
         exp_bit_ff      <= 1'b0;
         hist_idx_ff     <= '0;
         hist_wrapped_ff <= 1'b0;
         lost_count_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         local_seq_ff    <= local_seq_in;
         ack_timeout_ff  <= ack_timeout_in;
         local_port_ff   <= local_port_in;
         state_ff        <= state_in;
         peer_seq_ff     <= peer_seq_in;
         loss_pct_ff     <= loss_pct_in;
         hs_start_ff     <= hs_start_in;
         exp_bit_ff      <= exp_bit_in;
         hist_idx_ff     <= hist_idx_in;
         hist_wrapped_ff <= hist_wrapped_in;
         lost_count_ff   <= lost_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   // The read address runs one entry ahead of any write, so the two never meet.
   prr_ram #(
      .WIDTH (1),
      .DEPTH (WINDOW)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_wr),
      .wr_addr (hist_idx_ff),
      .wr_data (hist_bit),
      .rd_addr (hist_idx_in),
      .rd_data (hist_rd)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `PRR_ASSERT_IMPL(a_lost_bound, 1'b1, lost_count_ff <= LOSS_W'(WINDOW))
   `PRR_ASSERT_NEXT(a_conn_reply, req_fire && state_ff == ST_CONNECTED,
                    rsp_valid && rsp_payload.send_reply)
   `PRR_ASSERT_IMPL(a_deliver_excl, rsp_valid,
                    !(rsp_payload.deliver_payload && rsp_payload.loss_accepted))

endmodule
